FILE: rtl/nkps_pkg.sv
// ----------------------------------------------------------------------------
// nkps_pkg
// Types and constants shared by the nearest point select block.
// ----------------------------------------------------------------------------
`default_nettype none
package nkps_pkg;
   localparam int MaxPoints    = 32;
   localparam int NearestCount = 4;
   localparam int IdxW   = $clog2(MaxPoints);
   localparam int CountW = $clog2(MaxPoints + 1);
   localparam int SlotW  = (NearestCount > 1) ? $clog2(NearestCount) : 1;
   localparam int DistW  = 35;
   localparam int QDepth = 2;

   localparam logic [1:0] OpInsert = 2'd0;
   localparam logic [1:0] OpRemove = 2'd1;
   localparam logic [1:0] OpQuery  = 2'd2;
   localparam logic [1:0] OpUnused = 2'd3;

   localparam logic [1:0] StatOk       = 2'd0;
   localparam logic [1:0] StatFull     = 2'd1;
   localparam logic [1:0] StatNotFound = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         point_id;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
   } cmd_type;

   typedef struct packed {
      logic [7:0] result_id;
      logic [1:0] rank;
      logic       slot_valid;
      logic [1:0] status;
      logic       last;
   } rsp_type;
endpackage
`default_nettype wire

FILE: rtl/nkps_front.sv
// ----------------------------------------------------------------------------
// nkps_front
// Accepts transactions, drops unused op codes and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none
module nkps_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire nkps_pkg::cmd_type cmd_in,
   output nkps_pkg::cmd_type     cmd_out,
   output logic                  cmd_valid,
   input  wire logic             cmd_take
);
   localparam int PtrW = $clog2(nkps_pkg::QDepth);

   nkps_pkg::cmd_type    q_ff [nkps_pkg::QDepth];
   logic [PtrW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]        cnt_ff, cnt_in;
   logic                 wr_en, rd_en;

   // queue control; op 3 is accepted but never stored
   always_comb begin
      full   = (cnt_ff == (PtrW+1)'(nkps_pkg::QDepth));
      wr_en  = push && !full && (cmd_in.op != nkps_pkg::OpUnused);
      rd_en  = cmd_take && (cnt_ff != '0);
      wr_in  = wr_en ? PtrW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = rd_en ? PtrW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
      cmd_valid = (cnt_ff != '0);
      cmd_out   = q_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) q_ff[wr_ff] <= cmd_in;
   end
endmodule
`default_nettype wire

FILE: rtl/nkps_back.sv
// ----------------------------------------------------------------------------
// nkps_back
// Point store, sequential scan for remove and query, best list, result reg.
// ----------------------------------------------------------------------------
`default_nettype none
module nkps_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire nkps_pkg::cmd_type cmd,
   input  wire logic              cmd_valid,
   output logic                   cmd_take,
   output nkps_pkg::rsp_type      rsp,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop
);
   localparam int IW = nkps_pkg::IdxW;
   localparam int CW = nkps_pkg::CountW;
   localparam int SW = nkps_pkg::SlotW;
   localparam int NK = nkps_pkg::NearestCount;
   localparam int DW = nkps_pkg::DistW;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FIND  = 7'b0000010,
      S_SHIFT = 7'b0000100,
      S_SCAN  = 7'b0001000,
      S_WAIT  = 7'b0010000,
      S_OUT   = 7'b0100000,
      S_ONE   = 7'b1000000
   } state_type;

   state_type          st_ff, st_in;
   logic [7:0]         id_mem [nkps_pkg::MaxPoints];
   logic [47:0]        pos_mem [nkps_pkg::MaxPoints];
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      idx_ff;
   nkps_pkg::cmd_type  c_ff;
   logic [7:0]         rid_ff;
   logic [47:0]        rpos_ff;
   logic               rd_vld_ff;
   logic [7:0]         bid_ff [NK];
   logic [DW-1:0]      bd_ff [NK];
   logic [SW:0]        fill_ff;
   logic [SW:0]        oslot_ff;
   logic [1:0]         stat_ff;
   logic [DW-1:0]      sq_ff [3];
   logic [7:0]         sid_ff;
   logic               sv_ff;
   nkps_pkg::rsp_type  out_ff;
   logic               full_ff;

   // combinational helpers
   logic               mem_we, out_free, out_load, small_q;
   logic [IW-1:0]      we_addr, rd_addr;
   logic [7:0]         we_id;
   logic [47:0]        we_pos;
   logic [DW-1:0]      dsum;
   logic signed [16:0] dx, dy, dz;
   logic [16:0]        ax, ay, az;

   assign out_free  = !full_ff || rsp_pop;
   assign out_load  = out_free && (st_ff == S_OUT || st_ff == S_ONE);
   assign rsp       = out_ff;
   assign rsp_empty = !full_ff;
   assign small_q   = (count_ff <= CW'(NK));
   assign cmd_take  = (st_ff == S_IDLE) && cmd_valid;
   assign rd_addr   = idx_ff[IW-1:0];

   // store write port: insert at end, or shift down during remove
   always_comb begin
      mem_we  = 1'b0;
      we_addr = count_ff[IW-1:0];
      we_id   = cmd.point_id;
      we_pos  = {cmd.pos_x, cmd.pos_y, cmd.pos_z};
      if (cmd_take && cmd.op == nkps_pkg::OpInsert
          && count_ff != CW'(nkps_pkg::MaxPoints)) begin
         mem_we = 1'b1;
      end else if (st_ff == S_SHIFT && rd_vld_ff) begin
         mem_we  = 1'b1;
         we_addr = IW'(idx_ff - 2'd2);
         we_id   = rid_ff;
         we_pos  = rpos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         id_mem[we_addr]  <= we_id;
         pos_mem[we_addr] <= we_pos;
      end
      rid_ff  <= id_mem[rd_addr];
      rpos_ff <= pos_mem[rd_addr];
   end

   // distance stage: squares registered, then summed
   always_comb begin
      dx = 17'(signed'(rpos_ff[47:32])) - 17'(c_ff.pos_x);
      dy = 17'(signed'(rpos_ff[31:16])) - 17'(c_ff.pos_y);
      dz = 17'(signed'(rpos_ff[15:0]))  - 17'(c_ff.pos_z);
      ax = dx[16] ? 17'(-dx) : 17'(dx);
      ay = dy[16] ? 17'(-dy) : 17'(dy);
      az = dz[16] ? 17'(-dz) : 17'(dz);
      dsum = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   // sequencer
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE:  if (cmd_take) begin
            unique case (cmd.op)
               nkps_pkg::OpRemove: st_in = S_FIND;
               nkps_pkg::OpQuery:  st_in = S_SCAN;
               default:            st_in = S_ONE;
            endcase
         end
         S_FIND:  if (rd_vld_ff && rid_ff == c_ff.point_id) st_in = S_SHIFT;
                  else if (idx_ff >= count_ff && !rd_vld_ff) st_in = S_ONE;
         S_SHIFT: if (idx_ff > count_ff) st_in = S_ONE;
         S_SCAN:  if (idx_ff >= count_ff) st_in = S_WAIT;
         S_WAIT:  if (!rd_vld_ff && !sv_ff) st_in = S_OUT;
         S_OUT:   if (out_free && oslot_ff == (SW+1)'(NK - 1)) st_in = S_IDLE;
         S_ONE:   if (out_free) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; count_ff <= '0; full_ff <= 1'b0;
         rd_vld_ff <= 1'b0; sv_ff <= 1'b0; fill_ff <= '0;
      end else begin
         st_ff <= st_in;
         full_ff <= out_load || (full_ff && !rsp_pop);
         // read pipe valid: one read issued per cycle while scanning
         rd_vld_ff <= ((st_ff == S_FIND || st_ff == S_SCAN || st_ff == S_SHIFT)
                       && idx_ff < count_ff && st_in == st_ff);
         sv_ff <= rd_vld_ff && (st_ff == S_SCAN || st_ff == S_WAIT);
         unique case (st_ff)
            S_IDLE: if (cmd_take) begin
               idx_ff <= '0; oslot_ff <= '0; stat_ff <= nkps_pkg::StatOk;
               fill_ff <= '0;
               if (cmd.op == nkps_pkg::OpInsert) begin
                  if (count_ff == CW'(nkps_pkg::MaxPoints))
                     stat_ff <= nkps_pkg::StatFull;
                  else count_ff <= count_ff + 1'b1;
               end
            end
            S_FIND: begin
               if (rd_vld_ff && rid_ff == c_ff.point_id) idx_ff <= idx_ff;
               else if (idx_ff < count_ff) idx_ff <= idx_ff + 1'b1;
               if (idx_ff >= count_ff && !rd_vld_ff)
                  stat_ff <= nkps_pkg::StatNotFound;
            end
            S_SHIFT: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff > count_ff) count_ff <= count_ff - 1'b1;
            end
            S_SCAN: if (idx_ff < count_ff) idx_ff <= idx_ff + 1'b1;
            default: ;
         endcase
         // best list insertion, or store order for small stores
         if (sv_ff) begin
            if (small_q) begin
               if (fill_ff < (SW+1)'(NK)) begin
                  bid_ff[fill_ff[SW-1:0]] <= sid_ff;
                  fill_ff <= fill_ff + 1'b1;
               end
            end else begin
               for (int s = NK - 1; s >= 0; s--) begin
                  if ((SW+1)'(s) < fill_ff && dsum < bd_ff[s]) begin
                     if (s + 1 < NK) begin
                        bid_ff[s+1] <= bid_ff[s]; bd_ff[s+1] <= bd_ff[s];
                     end
                     if (s == 0 || !(dsum < bd_ff[s-1 < 0 ? 0 : s-1])) begin
                        bid_ff[s] <= sid_ff; bd_ff[s] <= dsum;
                     end
                  end else if ((SW+1)'(s) == fill_ff) begin
                     if (s == 0 || !(dsum < bd_ff[s-1 < 0 ? 0 : s-1])) begin
                        bid_ff[s] <= sid_ff; bd_ff[s] <= dsum;
                     end
                  end
               end
               if (fill_ff < (SW+1)'(NK)) fill_ff <= fill_ff + 1'b1;
            end
         end
         // result register
         if (out_load) begin
            if (st_ff == S_ONE) begin
               out_ff <= '{result_id: 8'd0, rank: 2'd0, slot_valid: 1'b0,
                          status: stat_ff, last: 1'b1};
            end else begin
               out_ff.result_id  <= (oslot_ff < fill_ff) ? bid_ff[oslot_ff[SW-1:0]]
                                                          : 8'd0;
               out_ff.rank       <= 2'(oslot_ff);
               out_ff.slot_valid <= (oslot_ff < fill_ff);
               out_ff.status     <= nkps_pkg::StatOk;
               out_ff.last       <= (oslot_ff == (SW+1)'(NK - 1));
               oslot_ff <= oslot_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) c_ff <= cmd;
      sq_ff[0] <= DW'(34'(ax) * 34'(ax));
      sq_ff[1] <= DW'(34'(ay) * 34'(ay));
      sq_ff[2] <= DW'(34'(az) * 34'(az));
      sid_ff   <= rid_ff;
   end
endmodule
`default_nettype wire

FILE: rtl/nearest_k_point_select.sv
// ----------------------------------------------------------------------------
// nearest_k_point_select
// Point store with insert, remove by id and k-nearest query.
// ----------------------------------------------------------------------------
// Input channel: req_* fields, taken when push is high and full is low.
// Result channel: rsp_* fields shown while empty is low, taken with pop.
// Insert gives one result without a scan of the store.
// Remove gives one result after a scan of the store to the matching id
// and a shift of the later entries.
// Query gives NearestCount results after one pass over the store, one
// stored point a cycle through the store read port and a two stage
// distance pipe.
// The back end takes a new command only once it is done with the last one.
// A two entry command queue lets new transactions be taken while the
// back end works; unused op codes are taken and yield no result.
// Reset empties the store and the queue at once.
// When the receiver stalls the result register holds and the back end
// waits; the command queue fills and then full rises.
// ----------------------------------------------------------------------------
`default_nettype none
module nearest_k_point_select (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  req_op,
   input  wire logic [7:0]  req_point_id,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic signed [15:0] req_pos_z,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_result_id,
   output logic [1:0]       rsp_rank,
   output logic             rsp_slot_valid,
   output logic [1:0]       rsp_status,
   output logic             rsp_last
);
   nkps_pkg::cmd_type cmd_in, cmd_q;
   nkps_pkg::rsp_type rsp;
   logic              cmd_valid, cmd_take;

   assign cmd_in = '{op: req_op, point_id: req_point_id, pos_x: req_pos_x,
                     pos_y: req_pos_y, pos_z: req_pos_z};

   nkps_front u_front (
      .clock, .reset, .push, .full, .cmd_in,
      .cmd_out(cmd_q), .cmd_valid, .cmd_take
   );

   nkps_back u_back (
      .clock, .reset, .cmd(cmd_q), .cmd_valid, .cmd_take,
      .rsp, .rsp_empty(empty), .rsp_pop(pop)
   );

   assign rsp_result_id  = rsp.result_id;
   assign rsp_rank       = rsp.rank;
   assign rsp_slot_valid = rsp.slot_valid;
   assign rsp_status     = rsp.status;
   assign rsp_last       = rsp.last;
endmodule
`default_nettype wire

FILE: rtl/nkps_checker.sv
// ----------------------------------------------------------------------------
// nkps_checker
// Port level checks on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none
module nkps_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       empty,
   input wire logic       pop,
   input wire logic [1:0] rsp_rank,
   input wire logic       rsp_slot_valid,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_last
);
   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_rank) && $stable(rsp_last)))
      else $error("result changed while stalled");
   // a valid slot never carries a status
   a_stat: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_slot_valid) |-> (rsp_status == nkps_pkg::StatOk))
      else $error("valid slot with status");
   // results with a non-ok status are single and final
   a_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != nkps_pkg::StatOk) |-> (rsp_last && rsp_rank == 2'd0))
      else $error("status result not final");
endmodule

bind nearest_k_point_select nkps_checker u_checker (
   .clock, .reset, .empty, .pop, .rsp_rank, .rsp_slot_valid, .rsp_status,
   .rsp_last
);
`default_nettype wire

FILE: tb/tb_nearest_k_point_select.sv
// ----------------------------------------------------------------------------
// tb_nearest_k_point_select
// Drives insert, remove and query transactions into the point store, keeps
// its own copy of the store to work out the expected results, and checks
// every result transaction field by field under varying idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_nearest_k_point_select;

   typedef struct packed {
      logic [7:0] result_id;
      logic [1:0] rank;
      logic       slot_valid;
      logic [1:0] status;
      logic       last;
   } slot_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic [1:0] req_op = '0;
   logic [7:0] req_point_id = '0;
   logic signed [15:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [7:0] rsp_result_id;
   logic [1:0] rsp_rank;
   logic rsp_slot_valid;
   logic [1:0] rsp_status;
   logic rsp_last;

   nearest_k_point_select u_top (
      .clock, .reset, .push, .full, .req_op, .req_point_id,
      .req_pos_x, .req_pos_y, .req_pos_z, .empty, .pop,
      .rsp_result_id, .rsp_rank, .rsp_slot_valid, .rsp_status, .rsp_last
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the point store
   logic [7:0]         shadow_ids [nkps_pkg::MaxPoints];
   logic signed [15:0] shadow_pos [nkps_pkg::MaxPoints][3];
   int                 shadow_count;

   slot_result_type expected_results[$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // append one expected result transaction
   function automatic void add_expected(input slot_result_type r);
      expected_results = {expected_results, r};
   endfunction

   // work out the results of one accepted transaction
   task automatic predict_results(input logic [1:0] op, input logic [7:0] pid,
                                  input logic signed [15:0] x,
                                  input logic signed [15:0] y,
                                  input logic signed [15:0] z);
      int found;
      logic [nkps_pkg::DistW-1:0] sq_dist;
      logic [nkps_pkg::DistW-1:0] near_dist[nkps_pkg::NearestCount];
      logic [7:0] near_id[nkps_pkg::NearestCount];
      int fill;
      logic signed [16:0] dx, dy, dz;
      slot_result_type r;
      r = '0;
      r.last = 1'b1;
      case (op)
         nkps_pkg::OpInsert: begin
            if (shadow_count >= nkps_pkg::MaxPoints) r.status = nkps_pkg::StatFull;
            else begin
               shadow_ids[shadow_count] = pid;
               shadow_pos[shadow_count][0] = x;
               shadow_pos[shadow_count][1] = y;
               shadow_pos[shadow_count][2] = z;
               shadow_count++;
            end
            add_expected(r);
         end
         nkps_pkg::OpRemove: begin
            found = -1;
            for (int i = 0; i < shadow_count; i++)
               if (found < 0 && shadow_ids[i] == pid) found = i;
            if (found < 0) r.status = nkps_pkg::StatNotFound;
            else begin
               for (int j = found; j + 1 < shadow_count; j++) begin
                  shadow_ids[j] = shadow_ids[j+1];
                  for (int a = 0; a < 3; a++) shadow_pos[j][a] = shadow_pos[j+1][a];
               end
               shadow_count--;
            end
            add_expected(r);
         end
         nkps_pkg::OpQuery: begin
            fill = 0;
            if (shadow_count <= nkps_pkg::NearestCount) begin
               for (int i = 0; i < shadow_count; i++) near_id[i] = shadow_ids[i];
               fill = shadow_count;
            end else begin
               for (int i = 0; i < shadow_count; i++) begin
                  dx = 17'(shadow_pos[i][0]) - 17'(x);
                  dy = 17'(shadow_pos[i][1]) - 17'(y);
                  dz = 17'(shadow_pos[i][2]) - 17'(z);
                  sq_dist = nkps_pkg::DistW'(34'(dx) * 34'(dx))
                          + nkps_pkg::DistW'(34'(dy) * 34'(dy))
                          + nkps_pkg::DistW'(34'(dz) * 34'(dz));
                  for (int s = 0; s < nkps_pkg::NearestCount; s++) begin
                     if (s >= fill) begin
                        near_id[s] = shadow_ids[i];
                        near_dist[s] = sq_dist;
                        fill++;
                        break;
                     end
                     if (sq_dist < near_dist[s]) begin
                        for (int j = nkps_pkg::NearestCount - 1; j > s; j--) begin
                           near_id[j] = near_id[j-1];
                           near_dist[j] = near_dist[j-1];
                        end
                        near_id[s] = shadow_ids[i];
                        near_dist[s] = sq_dist;
                        if (fill < nkps_pkg::NearestCount) fill++;
                        break;
                     end
                  end
               end
            end
            for (int s = 0; s < nkps_pkg::NearestCount; s++) begin
               r = '0;
               r.slot_valid = (s < fill);
               r.result_id = (s < fill) ? near_id[s] : 8'd0;
               r.rank = 2'(s);
               r.last = (s == nkps_pkg::NearestCount - 1);
               add_expected(r);
            end
         end
         default: ;
      endcase
   endtask

   // send one transaction, waiting out full
   task automatic send_item(input logic [1:0] op, input logic [7:0] pid,
                            input logic signed [15:0] x,
                            input logic signed [15:0] y,
                            input logic signed [15:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_op <= op;
      req_point_id <= pid;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      do @(posedge clock); while (full);
      predict_results(op, pid, x, y, z);
      @(negedge clock);
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      slot_result_type act, exp_r;
      if (!reset && pop && !empty) begin
         act = '{rsp_result_id, rsp_rank, rsp_slot_valid, rsp_status, rsp_last};
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", act);
         end else begin
            exp_r = expected_results.pop_front();
            if (act !== exp_r) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", exp_r, act);
            end
         end
      end
   end

   always @(negedge clock)
      pop <= ($urandom_range(99) >= recv_stall_pct);

   task automatic wait_drained();
      push <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (2 * nkps_pkg::MaxPoints + 20) @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_coord();
      case ($urandom_range(5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // extremes, every op, store full, unknown id, duplicates, unused op
   task automatic test_directed();
      send_item(nkps_pkg::OpQuery, 8'd0, '0, '0, '0);
      send_item(nkps_pkg::OpRemove, 8'd5, '0, '0, '0);
      send_item(nkps_pkg::OpInsert, 8'd255, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_item(nkps_pkg::OpInsert, 8'd0, 16'sh8000, 16'sh8000, 16'sh8000);
      send_item(nkps_pkg::OpInsert, 8'd7, '0, '0, '0);
      send_item(nkps_pkg::OpInsert, 8'd7, '0, '0, '0);
      send_item(nkps_pkg::OpQuery, 8'd0, '0, '0, '0);
      send_item(nkps_pkg::OpInsert, 8'd9, 16'sh0100, '0, '0);
      send_item(nkps_pkg::OpQuery, 8'd0, 16'sh8000, 16'sh8000, 16'sh8000);
      send_item(nkps_pkg::OpQuery, 8'd0, '0, '0, '0);
      send_item(nkps_pkg::OpUnused, 8'd1, '0, '0, '0);
      send_item(nkps_pkg::OpRemove, 8'd7, '0, '0, '0);
      send_item(nkps_pkg::OpQuery, 8'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      for (int i = 0; i < nkps_pkg::MaxPoints; i++)
         send_item(nkps_pkg::OpInsert, 8'(i), rand_coord(), rand_coord(), rand_coord());
      send_item(nkps_pkg::OpInsert, 8'd200, '0, '0, '0);
      send_item(nkps_pkg::OpQuery, 8'd0, '0, '0, '0);
      for (int i = 0; i < 5; i++) send_item(nkps_pkg::OpRemove, 8'(i * 3), '0, '0, '0);
   endtask

   // random mix biased to hit stored ids and fill the store
   task automatic test_random(input int n);
      logic [1:0] op;
      logic [7:0] pid;
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 40) op = nkps_pkg::OpInsert;
         else if (pick < 70) op = nkps_pkg::OpRemove;
         else if (pick < 97) op = nkps_pkg::OpQuery;
         else op = nkps_pkg::OpUnused;
         pid = ($urandom_range(1) && shadow_count > 0)
               ? shadow_ids[$urandom_range(shadow_count - 1)] : 8'($urandom);
         if ($urandom_range(3) == 0) pid = pid & 8'h07;
         send_item(op, pid, rand_coord(), rand_coord(), rand_coord());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(55);
      wait_drained();
      send_idle_pct = 65;
      test_random(55);
      send_idle_pct = 0;
      recv_stall_pct = 65;
      test_random(55);
      wait_drained();
      send_idle_pct = 6;
      recv_stall_pct = 6;
      test_random(55);
      recv_stall_pct = 0;
      wait_drained();
      if (mismatches == 0 && expected_results.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   // run time limit
   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
